// ===== rtl/kgsr_pkg.sv =====
// Shared types and constants for the k-group stream reverser.
package kgsr_pkg;

   localparam int MAX_GROUP  = 16;
   localparam int DATA_W     = 32;
   localparam int CNT_W      = $clog2(MAX_GROUP + 1);
   localparam int IDX_W      = $clog2(MAX_GROUP);
   localparam int NUM_BANKS  = 2;
   localparam int BANK_W     = 1;
   localparam int ADDR_W     = BANK_W + IDX_W;
   localparam int SIZE_W     = 5;
   localparam int Q_DEPTH    = 2;
   localparam int Q_PTR_W    = 1;
   localparam int Q_CNT_W    = 2;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1);

   // One finished group, handed from the front to the back
   typedef struct packed {
      logic [BANK_W-1:0] bank;
      logic [CNT_W-1:0]  count;
      logic              reverse;
      logic              last;
   } group_desc_type;

   typedef struct packed {
      logic           valid;
      group_desc_type desc;
   } group_push_type;

   // Group buffer write from the front
   typedef struct packed {
      logic                     en;
      logic [ADDR_W-1:0]        addr;
      logic signed [DATA_W-1:0] data;
   } buf_write_type;

   // Bank handed back by the back once fully read
   typedef struct packed {
      logic              valid;
      logic [BANK_W-1:0] bank;
   } bank_release_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== rtl/kgsr_front.sv =====
// Front end: accepts elements, fills the group banks and closes groups.
module kgsr_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [kgsr_pkg::DATA_W-1:0]      req_tdata,
   input  logic                             req_tlast,
   input  logic                             csr_wr_en,
   input  logic [kgsr_pkg::SIZE_W-1:0]      csr_wr_data,
   input  kgsr_pkg::bank_release_type       release_in,
   output kgsr_pkg::buf_write_type          buf_wr,
   output kgsr_pkg::group_push_type         push
);

   logic [kgsr_pkg::SIZE_W-1:0]    size_ff, size_in;
   logic [kgsr_pkg::CNT_W-1:0]     fill_ff, fill_in;
   logic [kgsr_pkg::BANK_W-1:0]    bank_ff, bank_in;
   logic [kgsr_pkg::NUM_BANKS-1:0] busy_ff, busy_in;
   logic [kgsr_pkg::CNT_W-1:0]     size_eff;
   logic [kgsr_pkg::CNT_W-1:0]     n_held;
   logic                           accept;
   logic                           full_group;
   logic                           close_group;

   // Clamp the programmed size to 1..MAX_GROUP
   always_comb begin
      priority if (size_ff == '0) begin
         size_eff = kgsr_pkg::CNT_W'(1);
      end else if (kgsr_pkg::CNT_W'(size_ff) > kgsr_pkg::CNT_W'(kgsr_pkg::MAX_GROUP)) begin
         size_eff = kgsr_pkg::CNT_W'(kgsr_pkg::MAX_GROUP);
      end else begin
         size_eff = kgsr_pkg::CNT_W'(size_ff);
      end
   end

   // Accept only into a bank the back has released
   assign req_tready  = ~busy_ff[bank_ff];
   assign accept      = req_tvalid & req_tready;
   assign n_held      = fill_ff + kgsr_pkg::CNT_W'(1);
   assign full_group  = n_held >= size_eff;
   assign close_group = full_group | req_tlast;

   // Write the element into the current bank
   always_comb begin
      buf_wr.en   = accept;
      buf_wr.addr = {bank_ff, fill_ff[kgsr_pkg::IDX_W-1:0]};
      buf_wr.data = req_tdata;
   end

   // Describe the closed group for the back
   always_comb begin
      push.valid        = accept & close_group;
      push.desc.bank    = bank_ff;
      push.desc.count   = n_held;
      push.desc.reverse = full_group;
      push.desc.last    = req_tlast;
   end

   // Next fill count, bank and busy flags
   always_comb begin
      size_in = csr_wr_en ? csr_wr_data : size_ff;
      fill_in = fill_ff;
      bank_in = bank_ff;
      busy_in = busy_ff;
      if (release_in.valid) begin
         busy_in[release_in.bank] = 1'b0;
      end
      if (accept) begin
         if (close_group) begin
            fill_in          = '0;
            bank_in          = ~bank_ff;
            busy_in[bank_ff] = 1'b1;
         end else begin
            fill_in = n_held;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= kgsr_pkg::SIZE_RESET;
         fill_ff <= '0;
         bank_ff <= '0;
         busy_ff <= '0;
      end else begin
         size_ff <= size_in;
         fill_ff <= fill_in;
         bank_ff <= bank_in;
         busy_ff <= busy_in;
      end
   end

endmodule

// ===== rtl/kgsr_queue.sv =====
// Short queue of closed-group descriptors between front and back.
module kgsr_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  kgsr_pkg::group_push_type    push,
   input  logic                        pop,
   output kgsr_pkg::group_desc_type    head,
   output kgsr_pkg::queue_status_type  status
);

   kgsr_pkg::group_desc_type      entry_ff [kgsr_pkg::Q_DEPTH];
   logic [kgsr_pkg::Q_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [kgsr_pkg::Q_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [kgsr_pkg::Q_CNT_W-1:0]  count_ff, count_in;
   logic                          do_push;
   logic                          do_pop;

   assign status.full  = count_ff == kgsr_pkg::Q_CNT_W'(kgsr_pkg::Q_DEPTH);
   assign status.empty = count_ff == '0;
   assign do_push      = push.valid & ~status.full;
   assign do_pop       = pop & ~status.empty;
   assign head         = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + kgsr_pkg::Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + kgsr_pkg::Q_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + kgsr_pkg::Q_CNT_W'(1);
         2'b01:   count_in = count_ff - kgsr_pkg::Q_CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the descriptor
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.desc;
      end
   end

endmodule

// ===== rtl/kgsr_back.sv =====
// Back end: holds the group banks and plays groups out in order or reversed.
module kgsr_back (
   input  logic                             clock,
   input  logic                             reset,
   input  kgsr_pkg::buf_write_type          buf_wr,
   input  kgsr_pkg::group_desc_type         head,
   input  kgsr_pkg::queue_status_type       q_status,
   output logic                             pop,
   output kgsr_pkg::bank_release_type       release_out,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [kgsr_pkg::DATA_W-1:0]      rsp_tdata,
   output logic                             rsp_tlast,
   output logic                             rsp_tuser
);

   logic signed [kgsr_pkg::DATA_W-1:0] group_mem [kgsr_pkg::NUM_BANKS * kgsr_pkg::MAX_GROUP];
   logic signed [kgsr_pkg::DATA_W-1:0] data_ff;
   logic                               valid_ff, valid_in;
   logic                               run_end_ff;
   logic                               list_end_ff;
   logic [kgsr_pkg::IDX_W-1:0]         rd_cnt_ff, rd_cnt_in;
   logic [kgsr_pkg::IDX_W-1:0]         last_idx;
   logic [kgsr_pkg::IDX_W-1:0]         rd_idx;
   logic                               rd_en;
   logic                               rd_last;

   // Read one element whenever a group is queued and the output register is free or draining
   assign rd_en    = ~q_status.empty & (~valid_ff | rsp_tready);
   assign last_idx = kgsr_pkg::IDX_W'(head.count - kgsr_pkg::CNT_W'(1));
   assign rd_last  = rd_cnt_ff == last_idx;
   assign rd_idx   = head.reverse ? last_idx - rd_cnt_ff : rd_cnt_ff;

   assign pop               = rd_en & rd_last;
   assign release_out.valid = pop;
   assign release_out.bank  = head.bank;

   // Advance the element counter and the output valid
   always_comb begin
      rd_cnt_in = rd_cnt_ff;
      if (rd_en) begin
         rd_cnt_in = rd_last ? '0 : rd_cnt_ff + kgsr_pkg::IDX_W'(1);
      end
      priority if (rd_en) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_cnt_ff <= '0;
         valid_ff  <= 1'b0;
      end else begin
         rd_cnt_ff <= rd_cnt_in;
         valid_ff  <= valid_in;
      end
   end

   // Group banks: one write port from the front, one registered read port
   always_ff @(posedge clock) begin
      if (buf_wr.en) begin
         group_mem[buf_wr.addr] <= buf_wr.data;
      end
      if (rd_en) begin
         data_ff     <= group_mem[{head.bank, rd_idx}];
         run_end_ff  <= rd_last;
         list_end_ff <= rd_last & head.last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = run_end_ff;
   assign rsp_tuser  = list_end_ff;

endmodule

// ===== rtl/k_group_stream_reverser_core.sv =====
// Top level of the k-group stream reverser: front, descriptor queue and back.
//
//   Channel  | Ports                          | Carries
//   ---------+--------------------------------+------------------------------------
//   req      | req_tvalid/tready/tdata/tlast  | tdata = value, tlast = list_last
//   rsp      | rsp_tvalid/tready/tdata/tlast/ | tdata = out_value, tlast = run_end,
//            | tuser                          | tuser = list_end
//   csr      | csr_wr_en/csr_wr_data          | group_size, written when wr_en high
//
// One element in and one result out per cycle while rsp_tready stays high.
// Two group banks alternate: the front fills one while the back reads the
// other through a single registered read port, so req_tready drops only while
// both banks hold groups not yet fully read out.
// A group's descriptor is registered in the queue before its first read.
// Reset is synchronous; it empties the queue and sets group_size to 1.
module k_group_stream_reverser_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [kgsr_pkg::DATA_W-1:0]  req_tdata,   // [31:0] value
   input  logic                         req_tlast,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [kgsr_pkg::DATA_W-1:0]  rsp_tdata,   // [31:0] out_value
   output logic                         rsp_tlast,
   output logic                         rsp_tuser,   // [0] list_end
   input  logic                         csr_wr_en,
   input  logic [kgsr_pkg::SIZE_W-1:0]  csr_wr_data
);

   kgsr_pkg::buf_write_type     buf_wr;
   kgsr_pkg::group_push_type    push;
   kgsr_pkg::group_desc_type    head;
   kgsr_pkg::queue_status_type  q_status;
   kgsr_pkg::bank_release_type  bank_release;
   logic                        pop;

   kgsr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .release_in  (bank_release),
      .buf_wr      (buf_wr),
      .push        (push)
   );

   kgsr_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .status (q_status)
   );

   kgsr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .buf_wr      (buf_wr),
      .head        (head),
      .q_status    (q_status),
      .pop         (pop),
      .release_out (bank_release),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

   // A closed group always finds room in the queue
   assert property (@(posedge clock) disable iff (reset) push.valid |-> !q_status.full)
      else $error("group closed while descriptor queue full");

   // A bank is released only while its descriptor heads the queue
   assert property (@(posedge clock) disable iff (reset)
                    bank_release.valid |-> !q_status.empty)
      else $error("bank released with empty queue");

   // The front never writes the bank being released
   assert property (@(posedge clock) disable iff (reset)
                    (buf_wr.en && bank_release.valid)
                    |-> (buf_wr.addr[kgsr_pkg::ADDR_W-1] != bank_release.bank))
      else $error("write into bank still being read");

   // List end only on the last result of a run
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("list end without run end");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the k-group stream reverser core.
`timescale 1ns / 1ps

module testbench;

   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD   = 300;
   localparam int SETTLE      = 8;
   localparam int RANDOM_ITEMS = 360;

   // One reordered element as it should leave the result channel
   typedef struct packed {
      logic [kgsr_pkg::DATA_W-1:0] value;
      logic                        run_end;
      logic                        list_end;
   } reordered_elem_type;

   // Group reordering predictor and store of pending results
   class group_reverse_scoreboard;
      logic [kgsr_pkg::DATA_W-1:0] held [kgsr_pkg::MAX_GROUP];
      int unsigned                 fill;
      logic [kgsr_pkg::SIZE_W-1:0] size_reg;
      reordered_elem_type          awaited [$];
      int unsigned                 errors;

      function new();
         fill     = 0;
         size_reg = kgsr_pkg::SIZE_RESET;
         errors   = 0;
      endfunction

      function void set_size(logic [kgsr_pkg::SIZE_W-1:0] s);
         size_reg = s;
      endfunction

      // Zero acts as pass-through, oversize saturates at the buffer depth
      function int unsigned group_len();
         int unsigned s;
         s = size_reg;
         if (s == 0) s = 1;
         if (s > kgsr_pkg::MAX_GROUP) s = kgsr_pkg::MAX_GROUP;
         return s;
      endfunction

      function void note_input(logic [kgsr_pkg::DATA_W-1:0] v, logic last);
         int unsigned n;
         reordered_elem_type e;
         if (fill >= kgsr_pkg::MAX_GROUP) fill = kgsr_pkg::MAX_GROUP - 1;
         held[kgsr_pkg::IDX_W'(fill)] = v;
         fill++;
         n = fill;
         if (n >= group_len()) begin
            // full group: newest first
            for (int unsigned i = 0; i < n; i++) begin
               e.value    = held[kgsr_pkg::IDX_W'(n - 1 - i)];
               e.run_end  = (i + 1 == n);
               e.list_end = (i + 1 == n) && last;
               awaited    = {awaited, e};
            end
            fill = 0;
         end else if (last) begin
            // short tail of a list: arrival order
            for (int unsigned i = 0; i < n; i++) begin
               e.value    = held[kgsr_pkg::IDX_W'(i)];
               e.run_end  = (i + 1 == n);
               e.list_end = (i + 1 == n);
               awaited    = {awaited, e};
            end
            fill = 0;
         end
      endfunction

      function void check_result(logic [kgsr_pkg::DATA_W-1:0] v, logic run_end,
                                 logic list_end);
         reordered_elem_type e;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected result value=%h run_end=%b list_end=%b",
                     $time, v, run_end, list_end);
            errors++;
         end else begin
            e = awaited.pop_front();
            if (e.value !== v) begin
               $display("%0t: out_value mismatch expected %h actual %h", $time, e.value, v);
               errors++;
            end
            if (e.run_end !== run_end) begin
               $display("%0t: run_end mismatch expected %b actual %b",
                        $time, e.run_end, run_end);
               errors++;
            end
            if (e.list_end !== list_end) begin
               $display("%0t: list_end mismatch expected %b actual %b",
                        $time, e.list_end, list_end);
               errors++;
            end
         end
      endfunction

      function int unsigned pending();
         return awaited.size();
      endfunction
   endclass

   logic                          clock       = 1'b0;
   logic                          reset       = 1'b1;
   logic                          req_tvalid  = 1'b0;
   logic                          req_tready;
   logic [kgsr_pkg::DATA_W-1:0]   req_tdata   = '0;   // [31:0] value
   logic                          req_tlast   = 1'b0;
   logic                          rsp_tvalid;
   logic                          rsp_tready  = 1'b0;
   logic [kgsr_pkg::DATA_W-1:0]   rsp_tdata;          // [31:0] out_value
   logic                          rsp_tlast;
   logic                          rsp_tuser;          // [0] list_end
   logic                          csr_wr_en   = 1'b0;
   logic [kgsr_pkg::SIZE_W-1:0]   csr_wr_data = '0;

   logic                no_idle       = 1'b0;
   int unsigned         hold_requests = 0;
   int unsigned         cycle_count   = 0;
   int unsigned         rx_gap        = 0;
   int unsigned         rx_hold       = 0;
   int unsigned         rx_holds_seen = 0;
   int unsigned         cur_size      = 1;

   group_reverse_scoreboard sb = new();

   k_group_stream_reverser_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Abandon the run if it hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Result side: check each transfer, then stall at random or on request
   always @(posedge clock) begin : result_sink
      logic ready_next;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            sb.check_result(rsp_tdata, rsp_tlast, rsp_tuser);
            rx_gap = no_idle ? 0 : $urandom_range(0, 7);
         end
         if (hold_requests != rx_holds_seen) begin
            rx_holds_seen = hold_requests;
            rx_hold       = LONG_HOLD;
         end
         if (rx_hold > 0) begin
            rx_hold--;
            ready_next = 1'b0;
         end else if (rx_gap > 0) begin
            rx_gap--;
            ready_next = 1'b0;
         end else begin
            ready_next = 1'b1;
         end
         rsp_tready <= ready_next;
      end
   end

   // Offer one element after a random gap and hold it until taken
   task automatic send_element(input logic [kgsr_pkg::DATA_W-1:0] v, input logic last);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_input(v, last);
   endtask

   // Stop offering and wait until every awaited result has left
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_group_size(input logic [kgsr_pkg::SIZE_W-1:0] s);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= s;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_size(s);
      cur_size = (s == 0) ? 1 : (s > kgsr_pkg::MAX_GROUP) ? kgsr_pkg::MAX_GROUP : s;
   endtask

   initial begin : stimulus
      logic [kgsr_pkg::DATA_W-1:0] corner [4];
      logic [kgsr_pkg::DATA_W-1:0] v;
      logic [kgsr_pkg::SIZE_W-1:0] size_pick [4];
      int unsigned                 sent;
      int unsigned                 phase;
      int unsigned                 phase_len;
      int unsigned                 list_left;

      corner    = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
      size_pick = '{5'd16, 5'd31, 5'd0, 5'd1};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Pass-through at the reset size, field extremes
      send_element(32'h7FFF_FFFF, 1'b0);
      send_element(32'h8000_0000, 1'b1);
      send_element(32'h0000_0000, 1'b0);
      send_element(32'hFFFF_FFFF, 1'b1);

      // Group that closes on a list end, then a short tail
      write_group_size(5'd3);
      send_element(32'h0000_0011, 1'b0);
      send_element(32'h0000_0022, 1'b0);
      send_element(32'h0000_0033, 1'b1);
      send_element(32'h0000_0044, 1'b0);
      send_element(32'h0000_0055, 1'b1);

      // Size lowered while a group is part filled
      write_group_size(5'd5);
      send_element(32'hA000_0001, 1'b0);
      send_element(32'hA000_0002, 1'b0);
      send_element(32'hA000_0003, 1'b0);
      write_group_size(5'd2);
      send_element(32'hA000_0004, 1'b0);

      // Size raised while a group is part filled
      send_element(32'hB000_0001, 1'b0);
      write_group_size(5'd4);
      send_element(32'hB000_0002, 1'b0);
      send_element(32'hB000_0003, 1'b0);
      send_element(32'hB000_0004, 1'b0);

      // Size zero behaves as pass-through
      write_group_size(5'd0);
      send_element(32'hC000_0001, 1'b0);
      send_element(32'hC000_0002, 1'b1);

      // Random phases: extremes of the size first, lists may span phases
      sent      = 0;
      phase     = 0;
      list_left = 0;
      while (sent < RANDOM_ITEMS) begin
         write_group_size(phase < 4 ? size_pick[2'(phase)]
                                    : kgsr_pkg::SIZE_W'($urandom_range(0, 31)));
         no_idle   <= ($urandom_range(0, 3) == 0);
         phase_len = $urandom_range(8, 30);
         if (phase == 5) begin
            // long receiver stall while the sender keeps going
            hold_requests <= hold_requests + 1;
            phase_len = 48;
         end
         for (int unsigned k = 0; k < phase_len; k++) begin
            if (list_left == 0) list_left = $urandom_range(1, 2 * cur_size + 2);
            v = ($urandom_range(0, 7) == 0) ? corner[2'($urandom_range(0, 3))] : $urandom();
            // mostly proper lists, now and then a stray list end
            send_element(v, (list_left == 1) || ($urandom_range(0, 31) == 0));
            list_left--;
            sent++;
         end
         phase++;
      end

      drain_results();
      if (sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
